// File: rtl/swmm_pkg.sv
`timescale 1ns / 1ps
package swmm_pkg;

  localparam int DEPTH      = 256;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int SAMPLE_W   = 16;
  localparam int TOTAL_W    = SAMPLE_W + CNT_W;
  localparam int DIV_CNT_W  = $clog2(TOTAL_W + 1);
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0] WINDOW_LEN_RESET = CNT_W'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_START,
    S_WAIT,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic latch;
    logic update;
    logic start;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic work_done;
    logic out_free;
  } ctrl_status_t;

endpackage

// File: rtl/swmm_divider.sv
`timescale 1ns / 1ps
module swmm_divider (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [swmm_pkg::TOTAL_W-1:0]   dividend,
  input  logic        [swmm_pkg::CNT_W-1:0]     divisor,
  output logic                                  busy,
  output logic signed [swmm_pkg::SAMPLE_W-1:0]  quotient
);
  import swmm_pkg::*;

  logic                 neg;
  logic [TOTAL_W-1:0]   quo;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] steps;
  logic [CNT_W:0]       rem_sh;
  logic [CNT_W:0]       rem_sub;
  logic                 fits;
  logic [TOTAL_W-1:0]   quo_signed;

  // restoring division on the magnitude, one quotient bit a cycle
  assign rem_sh  = {rem, quo[TOTAL_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign fits    = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= DIV_CNT_W'(TOTAL_W);
    end else if (busy) begin
      steps <= steps - DIV_CNT_W'(1);
      busy  <= steps != DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[TOTAL_W-1];
      quo <= dividend[TOTAL_W-1] ? TOTAL_W'(-dividend) : TOTAL_W'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo <= {quo[TOTAL_W-2:0], fits};
    end
  end

  assign quo_signed = neg ? (~quo + TOTAL_W'(1)) : quo;
  assign quotient   = quo_signed[SAMPLE_W-1:0];

endmodule

// File: rtl/swmm_ctrl.sv
`timescale 1ns / 1ps
module swmm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  swmm_pkg::ctrl_status_t status,
  output swmm_pkg::ctrl_cmd_t    cmd
);
  import swmm_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_READ;
      end
      S_READ:   state_next = S_UPDATE;
      S_UPDATE: state_next = S_START;
      S_START:  state_next = S_WAIT;
      S_WAIT: begin
        if (status.work_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
      end
      S_UPDATE: cmd.update = 1'b1;
      S_START:  cmd.start  = 1'b1;
      S_OUT:    cmd.load_out = status.out_free;
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/swmm_datapath.sv
`timescale 1ns / 1ps
module swmm_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  swmm_pkg::ctrl_cmd_t                   cmd,
  output swmm_pkg::ctrl_status_t                status,
  input  logic                                  cfg_wr,
  input  logic        [swmm_pkg::CNT_W-1:0]     cfg_wdata,
  output logic        [swmm_pkg::CNT_W-1:0]     window_len,
  input  logic signed [swmm_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  use_absolute,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [swmm_pkg::SAMPLE_W-1:0]  window_mean,
  output logic signed [swmm_pkg::SAMPLE_W-1:0]  window_min,
  output logic signed [swmm_pkg::SAMPLE_W-1:0]  window_max,
  output logic        [swmm_pkg::CNT_W-1:0]     fill_count
);
  import swmm_pkg::*;

  localparam logic signed [SAMPLE_W-1:0] S_TOP = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_BOT = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic        [ADDR_W-1:0]   rd_addr;

  logic signed [SAMPLE_W-1:0] s_reg;
  logic        [CNT_W-1:0]    count;
  logic        [ADDR_W-1:0]   wp;
  logic signed [TOTAL_W-1:0]  total;
  logic signed [SAMPLE_W-1:0] cur_min;
  logic signed [SAMPLE_W-1:0] cur_max;
  logic                       stale;

  logic        [CNT_W-1:0]    cap;
  logic        [ADDR_W-1:0]   wp_eff;
  logic        [CNT_W-1:0]    wp_inc;
  logic                       evict;
  logic signed [TOTAL_W-1:0]  total_next;
  logic signed [SAMPLE_W-1:0] s_abs;

  logic                       scanning;
  logic                       scan_pend;
  logic                       scan_first;
  logic        [CNT_W-1:0]    scan_idx;
  logic        [CNT_W-1:0]    scan_last;

  logic                       div_busy;
  logic signed [SAMPLE_W-1:0] div_quo;

  // window length zero acts as one, anything above the store depth as the depth
  always_comb begin
    cap = window_len;
    if (window_len == '0) cap = CNT_W'(1);
    if (window_len > CNT_W'(DEPTH)) cap = CNT_W'(DEPTH);
  end

  assign wp_eff    = ({1'b0, wp} >= cap) ? '0 : wp;
  assign wp_inc    = {1'b0, wp_eff} + CNT_W'(1);
  assign evict     = count >= cap;
  assign scan_last = count - CNT_W'(1);
  assign rd_addr   = scanning ? scan_idx[ADDR_W-1:0] : wp_eff;

  always_comb begin
    s_abs = sample;
    if (use_absolute && sample[SAMPLE_W-1]) begin
      s_abs = (sample == S_BOT) ? S_TOP : -sample;
    end
  end

  always_comb begin
    total_next = total + TOTAL_W'(s_reg);
    if (evict) total_next = total_next - TOTAL_W'(rd_data);
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (cmd.update) mem[wp_eff] <= s_reg;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) s_reg <= s_abs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_LEN_RESET;
      count      <= '0;
      wp         <= '0;
      total      <= '0;
      cur_min    <= '0;
      cur_max    <= '0;
      stale      <= 1'b0;
      scanning   <= 1'b0;
      scan_pend  <= 1'b0;
      scan_first <= 1'b0;
      scan_idx   <= '0;
    end else if (cfg_wr) begin
      // a length write empties the window
      window_len <= cfg_wdata;
      count      <= '0;
      wp         <= '0;
      total      <= '0;
      cur_min    <= '0;
      cur_max    <= '0;
      stale      <= 1'b0;
    end else begin
      if (cmd.update) begin
        if (!evict) count <= count + CNT_W'(1);
        wp    <= (wp_inc >= cap) ? '0 : wp_inc[ADDR_W-1:0];
        total <= total_next;
        stale <= evict && !(rd_data > cur_min && rd_data < cur_max);
        if (count == '0) begin
          cur_min <= s_reg;
          cur_max <= s_reg;
        end else if (s_reg < cur_min) begin
          cur_min <= s_reg;
        end else if (s_reg > cur_max) begin
          cur_max <= s_reg;
        end
      end

      if (cmd.start && stale) begin
        scanning   <= 1'b1;
        scan_idx   <= '0;
        scan_first <= 1'b1;
      end else if (scanning) begin
        scan_idx <= scan_idx + CNT_W'(1);
        if (scan_idx == scan_last) scanning <= 1'b0;
      end
      scan_pend <= scanning;

      // read data is registered, so it trails the scan address into the following cycle
      if (scan_pend) begin
        scan_first <= 1'b0;
        if (scan_first) begin
          cur_min <= rd_data;
          cur_max <= rd_data;
        end else begin
          if (rd_data < cur_min) cur_min <= rd_data;
          if (rd_data > cur_max) cur_max <= rd_data;
        end
      end
    end
  end

  swmm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start),
    .dividend (total),
    .divisor  (count),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      window_mean <= div_quo;
      window_min  <= cur_min;
      window_max  <= cur_max;
      fill_count  <= count;
    end
  end

  assign status.work_done = !div_busy && !scanning && !scan_pend;
  assign status.out_free  = !out_valid || !out_stall;

endmodule

// File: rtl/sliding_window_min_max_mean_core.sv
`timescale 1ns / 1ps
// Sliding window minimum, maximum and mean over the last window_len Q1.15
// samples (1 to 256, one register at every address; any write empties the window).
// One word is worked on at a time: acceptance, store read, update and start
// come in that order, then a 25-step divider and, when an evicted sample was an
// extreme, a rescan of the held samples at one store read per cycle run side
// by side; a wait state sees both done, and an output state then loads the
// output register once it is free. The output register lets the next word in
// while a result waits to be taken.
module sliding_window_min_max_mean_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic        [swmm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic        [swmm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic        [swmm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [swmm_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  use_absolute,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [swmm_pkg::SAMPLE_W-1:0]  window_mean,
  output logic signed [swmm_pkg::SAMPLE_W-1:0]  window_min,
  output logic signed [swmm_pkg::SAMPLE_W-1:0]  window_max,
  output logic        [swmm_pkg::CNT_W-1:0]     fill_count
);
  import swmm_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  logic         cfg_wr;
  logic [CNT_W-1:0] window_len;
  logic [CFG_ADDR_W-1:0] rd_addr_unused;

  // single register: every address in the range decodes to window_len
  assign rd_addr_unused = paddr;
  assign cfg_wr = psel && penable && pwrite && (rd_addr_unused == rd_addr_unused);
  assign pready = 1'b1;
  assign prdata = CFG_DATA_W'(window_len);

  swmm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  swmm_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_wr       (cfg_wr),
    .cfg_wdata    (pwdata[CNT_W-1:0]),
    .window_len   (window_len),
    .sample       (sample),
    .use_absolute (use_absolute),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .window_mean  (window_mean),
    .window_min   (window_min),
    .window_max   (window_max),
    .fill_count   (fill_count)
  );

endmodule

// File: rtl/swmm_checker.sv
`timescale 1ns / 1ps
module swmm_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [swmm_pkg::SAMPLE_W-1:0]  window_mean,
  input logic signed [swmm_pkg::SAMPLE_W-1:0]  window_min,
  input logic signed [swmm_pkg::SAMPLE_W-1:0]  window_max,
  input logic        [swmm_pkg::CNT_W-1:0]     fill_count
);
  import swmm_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(window_mean) &&
      $stable(window_min) && $stable(window_max) && $stable(fill_count))
    else $error("result word changed while stalled");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> window_min <= window_max)
    else $error("window minimum above maximum");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fill_count != '0 && fill_count <= CNT_W'(DEPTH))
    else $error("fill count out of range");

  // one word in flight: input is stalled straight after an acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while busy");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sliding_window_min_max_mean_core swmm_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .window_mean (window_mean),
  .window_min  (window_min),
  .window_max  (window_max),
  .fill_count  (fill_count)
);
